// ===== hw/rtl/sgi_pkg.sv =====
// Shared widths, types and helper functions of the segment intersection pipeline.
package sgi_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int OUT_BITS   = 32;

	// A coordinate difference, a product of two differences, and a cross product.
	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = 2 * DW;
	localparam int NW  = PW + 1;
	// The interpolation numerator, the quotient and the divider remainder.
	localparam int MW  = NW + DW + 1;
	localparam int QW  = COORD_BITS + FRAC_BITS + 1;
	localparam int RW  = NW;
	localparam int DVW = MW + FRAC_BITS;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (OUT_BITS - 1));

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DW-1:0]         diff_t;

	typedef struct packed {
		coord_t ax0;
		coord_t ay0;
		coord_t ax1;
		coord_t ay1;
		coord_t bx0;
		coord_t by0;
		coord_t bx1;
		coord_t by1;
	} seg_pair_t;

	// Outcome of the geometry tests; points are integer coordinates, zero when unset.
	typedef struct packed {
		logic [1:0] cnt;
		logic       use_div;
		coord_t     fx;
		coord_t     fy;
		coord_t     sx;
		coord_t     sy;
	} dec_t;

	typedef struct packed {
		logic          neg_x;
		logic          neg_y;
		logic [MW-1:0] num_x;
		logic [MW-1:0] num_y;
		logic [RW-1:0] den;
		dec_t          dec;
	} div_req_t;

	typedef struct packed {
		logic          neg_x;
		logic          neg_y;
		logic [QW-1:0] quo_x;
		logic [QW-1:0] quo_y;
		dec_t          dec;
	} div_rsp_t;

	function automatic diff_t ext(input coord_t c);
		return {c[COORD_BITS-1], c};
	endfunction

	function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > OUT_MAX) r = OUT_MAX;
		if (v < OUT_MIN) r = OUT_MIN;
		return r[OUT_BITS-1:0];
	endfunction

	function automatic logic signed [OUT_BITS-1:0] fix_int(input coord_t c);
		logic signed [63:0] v;
		v = {{(64 - COORD_BITS){c[COORD_BITS-1]}}, c};
		return sat_out(v <<< FRAC_BITS);
	endfunction

endpackage

// ===== hw/rtl/segment_intersection.sv =====
// Top level of the two-dimensional segment intersection pipeline.
//
// Each request carries two segments as eight signed 16-bit coordinates and produces exactly
// one result: hit_count is 0 when the segments are apart, 1 for a single crossing point and 2
// for a collinear overlap, with the points in signed Q16.16 and unset points reading zero.
// A crossing point that is not an endpoint is interpolated on the first segment and truncated
// toward zero. The block takes one request per cycle unless a result is held at the output, and
// each result is presented at the output having passed 40 register stages: six stages
// of box test, cross products, sign normalization, collinear point selection and interpolation
// products, then one stage per quotient bit in the 33-stage restoring divider, then the output
// register. The whole pipeline advances as one; it holds only while a result waits at the
// output under out_stall, so in_stall is raised exactly then. There is no configuration and
// no state kept between requests.
module segment_intersection (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [sgi_pkg::COORD_BITS-1:0] a_start_x,
	input  logic signed [sgi_pkg::COORD_BITS-1:0] a_start_y,
	input  logic signed [sgi_pkg::COORD_BITS-1:0] a_end_x,
	input  logic signed [sgi_pkg::COORD_BITS-1:0] a_end_y,
	input  logic signed [sgi_pkg::COORD_BITS-1:0] b_start_x,
	input  logic signed [sgi_pkg::COORD_BITS-1:0] b_start_y,
	input  logic signed [sgi_pkg::COORD_BITS-1:0] b_end_x,
	input  logic signed [sgi_pkg::COORD_BITS-1:0] b_end_y,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         hit_count,
	output logic signed [sgi_pkg::OUT_BITS-1:0] first_x,
	output logic signed [sgi_pkg::OUT_BITS-1:0] first_y,
	output logic signed [sgi_pkg::OUT_BITS-1:0] second_x,
	output logic signed [sgi_pkg::OUT_BITS-1:0] second_y
);
	import sgi_pkg::*;

	// All stages move together unless a finished result is being held at the output.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	seg_pair_t seg_in;
	assign seg_in = '{ax0: a_start_x, ay0: a_start_y, ax1: a_end_x, ay1: a_end_y,
		bx0: b_start_x, by0: b_start_y, bx1: b_end_x, by1: b_end_y};

	logic     req_v, rsp_v;
	div_req_t req;
	div_rsp_t rsp;

	sgi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in_valid),
		.seg_in (seg_in),
		.req_v  (req_v),
		.req    (req)
	);

	sgi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.req_v  (req_v),
		.req    (req),
		.rsp_v  (rsp_v),
		.rsp    (rsp)
	);

	// Apply the signs to the quotients, or expand the chosen endpoint to fixed point.
	logic signed [QW:0]           qx, qy;
	logic signed [OUT_BITS-1:0]   fx, fy;

	always_comb begin
		qx = rsp.neg_x ? -$signed({1'b0, rsp.quo_x}) : $signed({1'b0, rsp.quo_x});
		qy = rsp.neg_y ? -$signed({1'b0, rsp.quo_y}) : $signed({1'b0, rsp.quo_y});
		if (rsp.dec.use_div) begin
			fx = sat_out(64'(qx));
			fy = sat_out(64'(qy));
		end else begin
			fx = fix_int(rsp.dec.fx);
			fy = fix_int(rsp.dec.fy);
		end
	end

	logic                       out_valid_q;
	logic [1:0]                 hit_count_q;
	logic signed [OUT_BITS-1:0] first_x_q, first_y_q, second_x_q, second_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= rsp_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_count_q <= rsp.dec.cnt;
			first_x_q   <= fx;
			first_y_q   <= fy;
			second_x_q  <= fix_int(rsp.dec.sx);
			second_y_q  <= fix_int(rsp.dec.sy);
		end
	end

	assign out_valid = out_valid_q;
	assign hit_count = hit_count_q;
	assign first_x   = first_x_q;
	assign first_y   = first_y_q;
	assign second_x  = second_x_q;
	assign second_y  = second_y_q;

endmodule

// ===== hw/rtl/sgi_front.sv =====
// Front stages: box rejection, cross products, case decision and interpolation numerators.
module sgi_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  sgi_pkg::seg_pair_t  seg_in,
	output logic                req_v,
	output sgi_pkg::div_req_t   req
);
	import sgi_pkg::*;

	function automatic coord_t mx(input coord_t a, input coord_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic coord_t mn(input coord_t a, input coord_t b);
		return (a < b) ? a : b;
	endfunction

	// Range part of the point-on-segment test; on the collinear path the line test always holds.
	function automatic logic on_seg(input coord_t px, input coord_t py, input coord_t ax,
		input coord_t ay, input coord_t bx, input coord_t by);
		diff_t num;
		diff_t den;
		logic  r;
		r = 1'b0;
		if (ax != bx || ay != by) begin
			if (ax != bx) begin
				num = ext(px) - ext(ax);
				den = ext(bx) - ext(ax);
			end else begin
				num = ext(py) - ext(ay);
				den = ext(by) - ext(ay);
			end
			if (den > 0) r = (num >= 0) && (num <= den);
			else r = (num <= 0) && (num >= den);
		end
		return r;
	endfunction

	function automatic logic [2*COORD_BITS-1:0] pick(input seg_pair_t s, input logic [1:0] i);
		logic [2*COORD_BITS-1:0] r;
		case (i)
			2'd0:    r = {s.ax0, s.ay0};
			2'd1:    r = {s.ax1, s.ay1};
			2'd2:    r = {s.bx0, s.by0};
			default: r = {s.bx1, s.by1};
		endcase
		return r;
	endfunction

	// Stage 1: registered input.
	logic      v_s1;
	seg_pair_t seg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_v;
	end

	always_ff @(posedge clk) begin
		if (en) seg_s1 <= seg_in;
	end

	diff_t dxa, dya, dxb, dyb, ex, ey, ebx0, eby0, ebx1, eby1;
	logic signed [PW-1:0] prod [0:5];
	logic signed [PW-1:0] sq [0:5];
	logic rej;
	logic [3:0] hit;

	always_comb begin
		dxa  = ext(seg_s1.ax1) - ext(seg_s1.ax0);
		dya  = ext(seg_s1.ay1) - ext(seg_s1.ay0);
		dxb  = ext(seg_s1.bx1) - ext(seg_s1.bx0);
		dyb  = ext(seg_s1.by1) - ext(seg_s1.by0);
		ex   = ext(seg_s1.ax0) - ext(seg_s1.bx0);
		ey   = ext(seg_s1.ay0) - ext(seg_s1.by0);
		ebx0 = ext(seg_s1.bx0) - ext(seg_s1.ax0);
		eby0 = ext(seg_s1.by0) - ext(seg_s1.ay0);
		ebx1 = ext(seg_s1.bx1) - ext(seg_s1.ax0);
		eby1 = ext(seg_s1.by1) - ext(seg_s1.ay0);
		prod[0] = PW'(dxb) * PW'(ey);
		prod[1] = PW'(dyb) * PW'(ex);
		prod[2] = PW'(dxa) * PW'(ey);
		prod[3] = PW'(dya) * PW'(ex);
		prod[4] = PW'(dyb) * PW'(dxa);
		prod[5] = PW'(dxb) * PW'(dya);
		sq[0] = PW'(dxa) * PW'(dxa);
		sq[1] = PW'(dya) * PW'(dya);
		sq[2] = PW'(ebx0) * PW'(ebx0);
		sq[3] = PW'(eby0) * PW'(eby0);
		sq[4] = PW'(ebx1) * PW'(ebx1);
		sq[5] = PW'(eby1) * PW'(eby1);
		rej = (mx(seg_s1.ax0, seg_s1.ax1) < mn(seg_s1.bx0, seg_s1.bx1))
			|| (mx(seg_s1.bx0, seg_s1.bx1) < mn(seg_s1.ax0, seg_s1.ax1))
			|| (mx(seg_s1.ay0, seg_s1.ay1) < mn(seg_s1.by0, seg_s1.by1))
			|| (mx(seg_s1.by0, seg_s1.by1) < mn(seg_s1.ay0, seg_s1.ay1));
		hit[0] = on_seg(seg_s1.ax0, seg_s1.ay0, seg_s1.bx0, seg_s1.by0, seg_s1.bx1, seg_s1.by1);
		hit[1] = on_seg(seg_s1.ax1, seg_s1.ay1, seg_s1.bx0, seg_s1.by0, seg_s1.bx1, seg_s1.by1);
		hit[2] = on_seg(seg_s1.bx0, seg_s1.by0, seg_s1.ax0, seg_s1.ay0, seg_s1.ax1, seg_s1.ay1);
		hit[3] = on_seg(seg_s1.bx1, seg_s1.by1, seg_s1.ax0, seg_s1.ay0, seg_s1.ax1, seg_s1.ay1);
	end

	// Stage 2: products and squares.
	logic                 v_s2;
	seg_pair_t            seg_s2;
	logic signed [PW-1:0] prod_s2 [0:5];
	logic signed [PW-1:0] sq_s2 [0:5];
	logic                 rej_s2;
	logic [3:0]           hit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s2  <= seg_s1;
			prod_s2 <= prod;
			sq_s2   <= sq;
			rej_s2  <= rej;
			hit_s2  <= hit;
		end
	end

	// Stage 3: cross products, denominator and squared distances from the first start point.
	logic                 v_s3;
	seg_pair_t            seg_s3;
	logic signed [NW-1:0] n1_s3, n2_s3, d_s3;
	logic signed [NW-1:0] dae_s3, dbs_s3, dbe_s3;
	logic                 rej_s3;
	logic [3:0]           hit_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s3 <= seg_s2;
			n1_s3  <= NW'(prod_s2[0]) - NW'(prod_s2[1]);
			n2_s3  <= NW'(prod_s2[2]) - NW'(prod_s2[3]);
			d_s3   <= NW'(prod_s2[4]) - NW'(prod_s2[5]);
			dae_s3 <= NW'(sq_s2[0]) + NW'(sq_s2[1]);
			dbs_s3 <= NW'(sq_s2[2]) + NW'(sq_s2[3]);
			dbe_s3 <= NW'(sq_s2[4]) + NW'(sq_s2[5]);
			rej_s3 <= rej_s2;
			hit_s3 <= hit_s2;
		end
	end

	// Make the denominator nonnegative and pick the collinear overlap points.
	logic signed [NW-1:0]    nn1, nn2, nd, df;
	logic                    f_found, s_found, swap;
	logic [1:0]              fi, si;
	logic [2*COORD_BITS-1:0] cf, cs;

	always_comb begin
		if (d_s3 < 0) begin
			nd  = -d_s3;
			nn1 = -n1_s3;
			nn2 = -n2_s3;
		end else begin
			nd  = d_s3;
			nn1 = n1_s3;
			nn2 = n2_s3;
		end
		f_found = 1'b0;
		s_found = 1'b0;
		fi = 2'd0;
		si = 2'd0;
		for (int k = 0; k < 4; k++) begin
			if (hit_s3[k]) begin
				if (!f_found) begin
					f_found = 1'b1;
					fi = 2'(k);
				end else if (!s_found) begin
					s_found = 1'b1;
					si = 2'(k);
				end
			end
		end
		case (fi)
			2'd0:    df = '0;
			2'd1:    df = dae_s3;
			2'd2:    df = dbs_s3;
			default: df = dbe_s3;
		endcase
		swap = s_found && (si == 2'd3) && (dbe_s3 < df);
		cf = '0;
		cs = '0;
		if (f_found) cf = swap ? pick(seg_s3, 2'd3) : pick(seg_s3, fi);
		if (s_found) cs = swap ? pick(seg_s3, fi) : pick(seg_s3, si);
	end

	// Stage 4: normalized terms and collinear points.
	logic                    v_s4;
	seg_pair_t               seg_s4;
	logic signed [NW-1:0]    n1_s4, n2_s4, d_s4;
	logic                    rej_s4;
	logic [2*COORD_BITS-1:0] cf_s4, cs_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s4 <= seg_s3;
			n1_s4  <= nn1;
			n2_s4  <= nn2;
			d_s4   <= nd;
			rej_s4 <= rej_s3;
			cf_s4  <= cf;
			cs_s4  <= cs;
		end
	end

	dec_t                 dec;
	diff_t                dxa4, dya4;
	logic signed [MW-1:0] mxd, mxn, myd, myn;

	always_comb begin
		dec = '0;
		if (!rej_s4) begin
			if (d_s4 != 0) begin
				if (!(n1_s4 < 0 || n1_s4 > d_s4 || n2_s4 < 0 || n2_s4 > d_s4)) begin
					dec.cnt = CNT_ONE;
					if (n1_s4 == 0) begin
						dec.fx = seg_s4.ax0;
						dec.fy = seg_s4.ay0;
					end else if (n1_s4 == d_s4) begin
						dec.fx = seg_s4.ax1;
						dec.fy = seg_s4.ay1;
					end else if (n2_s4 == 0) begin
						dec.fx = seg_s4.bx0;
						dec.fy = seg_s4.by0;
					end else if (n2_s4 == d_s4) begin
						dec.fx = seg_s4.bx1;
						dec.fy = seg_s4.by1;
					end else begin
						dec.use_div = 1'b1;
					end
				end
			end else if (n1_s4 == 0 && n2_s4 == 0) begin
				dec.cnt = CNT_TWO;
				{dec.fx, dec.fy} = cf_s4;
				{dec.sx, dec.sy} = cs_s4;
			end
		end
		dxa4 = ext(seg_s4.ax1) - ext(seg_s4.ax0);
		dya4 = ext(seg_s4.ay1) - ext(seg_s4.ay0);
		mxd  = MW'(seg_s4.ax0) * MW'(d_s4);
		mxn  = MW'(n1_s4) * MW'(dxa4);
		myd  = MW'(seg_s4.ay0) * MW'(d_s4);
		myn  = MW'(n1_s4) * MW'(dya4);
	end

	// Stage 5: interpolation partial products.
	logic                 v_s5;
	dec_t                 dec_s5;
	logic signed [MW-1:0] mxd_s5, mxn_s5, myd_s5, myn_s5;
	logic [RW-1:0]        den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s5 <= dec;
			mxd_s5 <= mxd;
			mxn_s5 <= mxn;
			myd_s5 <= myd;
			myn_s5 <= myn;
			den_s5 <= d_s4;
		end
	end

	logic signed [MW-1:0] sum_x, sum_y;
	div_req_t             nreq;

	always_comb begin
		sum_x = mxd_s5 + mxn_s5;
		sum_y = myd_s5 + myn_s5;
		nreq.neg_x = sum_x[MW-1];
		nreq.neg_y = sum_y[MW-1];
		nreq.num_x = sum_x[MW-1] ? MW'(-sum_x) : MW'(sum_x);
		nreq.num_y = sum_y[MW-1] ? MW'(-sum_y) : MW'(sum_y);
		nreq.den   = den_s5;
		nreq.dec   = dec_s5;
	end

	// Stage 6: magnitudes and signs for the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) req_v <= 1'b0;
		else if (en) req_v <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) req <= nreq;
	end

endmodule

// ===== hw/rtl/sgi_div.sv =====
// Restoring divider, one quotient bit per pipeline stage, two numerators over one divisor.
module sgi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               req_v,
	input  sgi_pkg::div_req_t  req,
	output logic               rsp_v,
	output sgi_pkg::div_rsp_t  rsp
);
	import sgi_pkg::*;

	function automatic logic [RW:0] step(input logic [RW-1:0] rem, input logic b,
		input logic [RW-1:0] den);
		logic [RW:0] t;
		logic [RW:0] r;
		t = {rem, b};
		if (t >= {1'b0, den}) r = {RW'(t - {1'b0, den}), 1'b1};
		else r = {t[RW-1:0], 1'b0};
		return r;
	endfunction

	logic [DVW-1:0] dvd_x, dvd_y;

	assign dvd_x = DVW'(req.num_x) << FRAC_BITS;
	assign dvd_y = DVW'(req.num_y) << FRAC_BITS;

	logic          v_s     [0:QW-1];
	logic [RW-1:0] rem_x_s [0:QW-1];
	logic [RW-1:0] rem_y_s [0:QW-1];
	logic [QW-1:0] low_x_s [0:QW-1];
	logic [QW-1:0] low_y_s [0:QW-1];
	logic [QW-1:0] quo_x_s [0:QW-1];
	logic [QW-1:0] quo_y_s [0:QW-1];
	logic [RW-1:0] den_s   [0:QW-1];
	logic          neg_x_s [0:QW-1];
	logic          neg_y_s [0:QW-1];
	dec_t          dec_s   [0:QW-1];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic          vi;
		logic [RW-1:0] rxi, ryi, di;
		logic [QW-1:0] lxi, lyi, qxi, qyi;
		logic          nxi, nyi;
		dec_t          deci;
		logic [RW:0]   sx, sy;

		if (i == 0) begin : g_first
			assign vi   = req_v;
			assign rxi  = dvd_x[RW+QW-1:QW];
			assign ryi  = dvd_y[RW+QW-1:QW];
			assign lxi  = dvd_x[QW-1:0];
			assign lyi  = dvd_y[QW-1:0];
			assign qxi  = '0;
			assign qyi  = '0;
			assign di   = req.den;
			assign nxi  = req.neg_x;
			assign nyi  = req.neg_y;
			assign deci = req.dec;
		end else begin : g_next
			assign vi   = v_s[i-1];
			assign rxi  = rem_x_s[i-1];
			assign ryi  = rem_y_s[i-1];
			assign lxi  = low_x_s[i-1];
			assign lyi  = low_y_s[i-1];
			assign qxi  = quo_x_s[i-1];
			assign qyi  = quo_y_s[i-1];
			assign di   = den_s[i-1];
			assign nxi  = neg_x_s[i-1];
			assign nyi  = neg_y_s[i-1];
			assign deci = dec_s[i-1];
		end

		assign sx = step(rxi, lxi[QW-1], di);
		assign sy = step(ryi, lyi[QW-1], di);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (en) v_s[i] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_x_s[i] <= sx[RW:1];
				rem_y_s[i] <= sy[RW:1];
				low_x_s[i] <= lxi << 1;
				low_y_s[i] <= lyi << 1;
				quo_x_s[i] <= {qxi[QW-2:0], sx[0]};
				quo_y_s[i] <= {qyi[QW-2:0], sy[0]};
				den_s[i]   <= di;
				neg_x_s[i] <= nxi;
				neg_y_s[i] <= nyi;
				dec_s[i]   <= deci;
			end
		end
	end

	assign rsp_v     = v_s[QW-1];
	assign rsp.neg_x = neg_x_s[QW-1];
	assign rsp.neg_y = neg_y_s[QW-1];
	assign rsp.quo_x = quo_x_s[QW-1];
	assign rsp.quo_y = quo_y_s[QW-1];
	assign rsp.dec   = dec_s[QW-1];

endmodule

// ===== hw/rtl/sgi_chk.sv =====
// Port-level assertions for the segment intersection pipeline, bound to its top level.
module sgi_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [1:0]                         hit_count,
	input logic signed [sgi_pkg::OUT_BITS-1:0] first_x,
	input logic signed [sgi_pkg::OUT_BITS-1:0] first_y,
	input logic signed [sgi_pkg::OUT_BITS-1:0] second_x,
	input logic signed [sgi_pkg::OUT_BITS-1:0] second_y
);
	import sgi_pkg::*;

	// The input side only waits while a result is held at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall raised without a held result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(hit_count) && $stable(first_x)
			&& $stable(second_x)))
		else $error("held result changed");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit_count == CNT_NONE) |-> (first_x == 0 && first_y == 0
			&& second_x == 0 && second_y == 0))
		else $error("points set on a miss");

	a_one_second: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit_count == CNT_ONE) |-> (second_x == 0 && second_y == 0))
		else $error("second point set on a single crossing");

endmodule

bind segment_intersection sgi_chk u_sgi_chk (.*);
